// ===== rtl/core/byte_run_length_encoder_macros.svh =====
// Assertion macros shared by the run-length encoder RTL.
// Included by the modules that check their own control logic.
`ifndef BYTE_RUN_LENGTH_ENCODER_MACROS_SVH
`define BYTE_RUN_LENGTH_ENCODER_MACROS_SVH
`ifndef SYNTHESIS
`define BRLE_ASSERT(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (prop)) else $error(msg);
`define BRLE_NEVER(lbl, ck, rs, cond, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) !(cond)) else $error(msg);
`else
`define BRLE_ASSERT(lbl, ck, rs, prop, msg)
`define BRLE_NEVER(lbl, ck, rs, cond, msg)
`endif
`endif

// ===== rtl/core/brle_pkg.sv =====
// Types, constants and command format of the byte run-length encoder.
// No dependencies; all files but the RAM and macro header import it.
`default_nettype none
package brle_pkg;

  localparam int LIT_MAX_DEFAULT = 127;
  localparam int RUN_MAX_DEFAULT = 130;
  localparam int DATA_W          = 8;
  localparam int LC_W            = 7;
  localparam int RL_W            = 8;
  localparam int WORD_BYTES      = 8;
  localparam int WORD_W          = WORD_BYTES * DATA_W;
  localparam int CNT_W           = 4;
  localparam int QUEUE_DEPTH     = 4;
  localparam int RUN_MIN         = 3;

  localparam logic [DATA_W-1:0] HDR_BASE   = 8'hFF;
  localparam logic [DATA_W-1:0] TERM_BYTE  = 8'h00;
  localparam logic [DATA_W-1:0] END_PLAIN  = 8'h00;
  localparam logic [DATA_W-1:0] END_TERM   = 8'h01;

  typedef enum logic [1:0] {
    CMD_FLUSH,
    CMD_RUN,
    CMD_END
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t           op;
    logic [DATA_W-1:0] arg;
    logic [DATA_W-1:0] val;
  } cmd_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_EVAL,
    F_CL_FLUSH,
    F_CL_BODY,
    F_FIN,
    F_FIN_FLUSH,
    F_TERM
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_RUNVAL,
    B_LRD,
    B_LWR,
    B_FINAL
  } back_state_t;

endpackage
`default_nettype wire

// ===== rtl/core/brle_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none
module brle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/brle_cmd_fifo.sv =====
// Short command queue between the encoder front and back.
// Depends on brle_pkg for the command type and depth.
`default_nettype none
module brle_cmd_fifo import brle_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t wr_cmd,
  output logic      full,
  input  wire logic pop,
  output cmd_t      rd_cmd,
  output logic      empty
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          mem [QUEUE_DEPTH];
  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;
  logic [CW-1:0] cnt;
  logic          do_push;
  logic          do_pop;

  assign full    = (cnt == CW'(QUEUE_DEPTH));
  assign empty   = (cnt == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_cmd  = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == AW'(QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == AW'(QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10: begin
          cnt <= cnt + 1'b1;
        end
        2'b01: begin
          cnt <= cnt - 1'b1;
        end
        default: begin
          cnt <= cnt;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/brle_front.sv =====
// Encoder front: accepts input bytes, tracks the run and the literal
// count, writes literal bytes and queues output commands. Uses brle_pkg.
`default_nettype none
`include "byte_run_length_encoder_macros.svh"
module brle_front import brle_pkg::*; #(
  parameter int LIT_MAX = LIT_MAX_DEFAULT,
  parameter int RUN_MAX = RUN_MAX_DEFAULT,
  localparam int AW = $clog2(LIT_MAX)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [DATA_W-1:0] data_byte,
  input  wire logic              is_final,
  output logic                   q_push,
  output cmd_t                   q_cmd,
  input  wire logic              q_full,
  input  wire logic              flush_done,
  output logic                   ram_we,
  output logic      [AW-1:0]     ram_waddr,
  output logic      [DATA_W-1:0] ram_wdata
);

  localparam int FCW = $clog2(QUEUE_DEPTH + 2);

  front_state_t      state, state_next;
  logic [DATA_W-1:0] b_reg, b_reg_next;
  logic              fin_reg, fin_reg_next;
  logic [DATA_W-1:0] rv, rv_next;
  logic [RL_W-1:0]   rl, rl_next;
  logic [LC_W-1:0]   lc, lc_next;
  logic [RL_W-1:0]   cl_len, cl_len_next;
  logic [DATA_W-1:0] cl_val, cl_val_next;
  logic              cl_force, cl_force_next;
  logic [FCW-1:0]    flush_cnt;
  logic [8:0]        lit_sum;
  logic [RL_W-1:0]   rl_inc;
  logic              need_flush;
  logic              extend;
  logic              flush_push;

  assign lit_sum    = {2'b00, lc} + {1'b0, cl_len};
  assign need_flush = (lc != '0) &&
                      (cl_force || (cl_len >= RL_W'(RUN_MIN)) || (lit_sum > 9'(LIT_MAX)));
  assign extend     = (rl != '0) && (b_reg == rv) && (rl < RL_W'(RUN_MAX));
  assign rl_inc     = rl + 1'b1;
  assign flush_push = q_push && (q_cmd.op == CMD_FLUSH);
  assign in_stall   = (state != F_IDLE);
  assign ram_waddr  = lc[AW-1:0];
  assign ram_wdata  = cl_val;

  always_comb begin
    state_next    = state;
    b_reg_next    = b_reg;
    fin_reg_next  = fin_reg;
    rv_next       = rv;
    rl_next       = rl;
    lc_next       = lc;
    cl_len_next   = cl_len;
    cl_val_next   = cl_val;
    cl_force_next = cl_force;
    q_push        = 1'b0;
    q_cmd         = '{op: CMD_END, arg: END_PLAIN, val: '0};
    ram_we        = 1'b0;
    case (state)
      F_IDLE: begin
        if (in_valid) begin
          b_reg_next   = data_byte;
          fin_reg_next = is_final;
          state_next   = F_EVAL;
        end
      end
      F_EVAL: begin
        if (extend) begin
          if (rl_inc == RL_W'(RUN_MAX)) begin
            cl_len_next   = rl_inc;
            cl_val_next   = rv;
            cl_force_next = 1'b0;
            rl_next       = '0;
            state_next    = F_CL_FLUSH;
          end else begin
            rl_next    = rl_inc;
            state_next = F_FIN;
          end
        end else begin
          rv_next = b_reg;
          rl_next = RL_W'(1);
          if (rl != '0) begin
            cl_len_next   = rl;
            cl_val_next   = rv;
            cl_force_next = 1'b0;
            state_next    = F_CL_FLUSH;
          end else begin
            state_next = F_FIN;
          end
        end
      end
      F_CL_FLUSH: begin
        if (!need_flush) begin
          state_next = F_CL_BODY;
        end else if (!q_full) begin
          q_push     = 1'b1;
          q_cmd      = '{op: CMD_FLUSH, arg: {1'b0, lc}, val: '0};
          lc_next    = '0;
          state_next = F_CL_BODY;
        end
      end
      F_CL_BODY: begin
        if (cl_len >= RL_W'(RUN_MIN)) begin
          if (!q_full) begin
            q_push     = 1'b1;
            q_cmd      = '{op: CMD_RUN, arg: HDR_BASE - (cl_len - RL_W'(RUN_MIN)),
                           val: cl_val};
            state_next = cl_force ? F_FIN_FLUSH : F_FIN;
          end
        end else if (flush_cnt == '0) begin
          ram_we      = 1'b1;
          lc_next     = lc + 1'b1;
          cl_len_next = cl_len - 1'b1;
          if (cl_len == RL_W'(1)) begin
            state_next = cl_force ? F_FIN_FLUSH : F_FIN;
          end
        end
      end
      F_FIN: begin
        if (!fin_reg) begin
          if (!q_full) begin
            q_push     = 1'b1;
            q_cmd      = '{op: CMD_END, arg: END_PLAIN, val: '0};
            state_next = F_IDLE;
          end
        end else begin
          rv_next = '0;
          rl_next = '0;
          if (rl != '0) begin
            cl_len_next   = rl;
            cl_val_next   = rv;
            cl_force_next = 1'b1;
            state_next    = F_CL_FLUSH;
          end else begin
            state_next = F_FIN_FLUSH;
          end
        end
      end
      F_FIN_FLUSH: begin
        if (lc == '0) begin
          state_next = F_TERM;
        end else if (!q_full) begin
          q_push     = 1'b1;
          q_cmd      = '{op: CMD_FLUSH, arg: {1'b0, lc}, val: '0};
          lc_next    = '0;
          state_next = F_TERM;
        end
      end
      F_TERM: begin
        if (!q_full) begin
          q_push     = 1'b1;
          q_cmd      = '{op: CMD_END, arg: END_TERM, val: '0};
          state_next = F_IDLE;
        end
      end
      default: begin
        state_next = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= F_IDLE;
      rv        <= '0;
      rl        <= '0;
      lc        <= '0;
      flush_cnt <= '0;
    end else begin
      state <= state_next;
      rv    <= rv_next;
      rl    <= rl_next;
      lc    <= lc_next;
      case ({flush_push, flush_done})
        2'b10: begin
          flush_cnt <= flush_cnt + 1'b1;
        end
        2'b01: begin
          flush_cnt <= flush_cnt - 1'b1;
        end
        default: begin
          flush_cnt <= flush_cnt;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    b_reg    <= b_reg_next;
    fin_reg  <= fin_reg_next;
    cl_len   <= cl_len_next;
    cl_val   <= cl_val_next;
    cl_force <= cl_force_next;
  end

  `BRLE_ASSERT(a_lit_bound, clk, rst, lc <= LC_W'(LIT_MAX), "literal count above limit")
  `BRLE_ASSERT(a_run_bound, clk, rst, (state == F_IDLE) |-> (rl < RL_W'(RUN_MAX)), "run not closed")
  `BRLE_NEVER(a_flush_ack, clk, rst, flush_done && (flush_cnt == '0), "flush done with none pending")

endmodule
`default_nettype wire

// ===== rtl/core/brle_back.sv =====
// Encoder back: executes queued commands, reads literal bytes and packs
// output bytes into words behind an output register. Uses brle_pkg.
`default_nettype none
`include "byte_run_length_encoder_macros.svh"
module brle_back import brle_pkg::*; #(
  parameter int LIT_MAX = LIT_MAX_DEFAULT,
  localparam int AW = $clog2(LIT_MAX)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              q_empty,
  input  wire cmd_t              q_cmd,
  output logic                   q_pop,
  output logic                   flush_done,
  output logic                   ram_re,
  output logic      [AW-1:0]     ram_raddr,
  input  wire logic [DATA_W-1:0] ram_rdata,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic      [WORD_W-1:0] packed_bytes,
  output logic      [CNT_W-1:0]  byte_count,
  output logic                   last_for_item,
  output logic                   stream_done
);

  back_state_t       state, state_next;
  logic [DATA_W-1:0] cur_arg, cur_arg_next;
  logic [DATA_W-1:0] cur_val, cur_val_next;
  logic [LC_W-1:0]   idx, idx_next;
  logic [LC_W-1:0]   idx_inc;
  logic [WORD_W-1:0] acc;
  logic [CNT_W-1:0]  acc_cnt;
  logic              out_free;
  logic              byte_ok;
  logic              push_en;
  logic [DATA_W-1:0] push_byte;
  logic              fin_en;
  logic              fin_term;
  logic              word_load;

  assign out_free  = !out_valid || !out_stall;
  assign byte_ok   = (acc_cnt != CNT_W'(WORD_BYTES)) || out_free;
  assign idx_inc   = idx + 1'b1;
  assign ram_raddr = idx[AW-1:0];
  assign word_load = (push_en && (acc_cnt == CNT_W'(WORD_BYTES))) ||
                     (fin_en && (acc_cnt != '0));

  always_comb begin
    state_next   = state;
    cur_arg_next = cur_arg;
    cur_val_next = cur_val;
    idx_next     = idx;
    q_pop        = 1'b0;
    flush_done   = 1'b0;
    ram_re       = 1'b0;
    push_en      = 1'b0;
    push_byte    = q_cmd.arg;
    fin_en       = 1'b0;
    fin_term     = 1'b0;
    case (state)
      B_IDLE: begin
        if (!q_empty) begin
          case (q_cmd.op)
            CMD_FLUSH: begin
              if (byte_ok) begin
                q_pop        = 1'b1;
                push_en      = 1'b1;
                cur_arg_next = q_cmd.arg;
                idx_next     = '0;
                state_next   = B_LRD;
              end
            end
            CMD_RUN: begin
              if (byte_ok) begin
                q_pop        = 1'b1;
                push_en      = 1'b1;
                cur_val_next = q_cmd.val;
                state_next   = B_RUNVAL;
              end
            end
            CMD_END: begin
              if (q_cmd.arg == END_TERM) begin
                if (byte_ok) begin
                  q_pop      = 1'b1;
                  push_en    = 1'b1;
                  push_byte  = TERM_BYTE;
                  state_next = B_FINAL;
                end
              end else if (out_free || (acc_cnt == '0)) begin
                q_pop  = 1'b1;
                fin_en = 1'b1;
              end
            end
            default: begin
              q_pop = 1'b1;
            end
          endcase
        end
      end
      B_RUNVAL: begin
        push_byte = cur_val;
        if (byte_ok) begin
          push_en    = 1'b1;
          state_next = B_IDLE;
        end
      end
      B_LRD: begin
        ram_re     = 1'b1;
        flush_done = (idx_inc == cur_arg[LC_W-1:0]);
        state_next = B_LWR;
      end
      B_LWR: begin
        push_byte = ram_rdata;
        if (byte_ok) begin
          push_en    = 1'b1;
          idx_next   = idx_inc;
          state_next = (idx_inc == cur_arg[LC_W-1:0]) ? B_IDLE : B_LRD;
        end
      end
      B_FINAL: begin
        if (out_free) begin
          fin_en     = 1'b1;
          fin_term   = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    cur_arg <= cur_arg_next;
    cur_val <= cur_val_next;
    idx     <= idx_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      acc       <= '0;
      acc_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (word_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (push_en) begin
        if (acc_cnt == CNT_W'(WORD_BYTES)) begin
          packed_bytes  <= acc;
          byte_count    <= acc_cnt;
          last_for_item <= 1'b0;
          stream_done   <= 1'b0;
          acc           <= WORD_W'(push_byte);
          acc_cnt       <= CNT_W'(1);
        end else begin
          acc[{acc_cnt[2:0], 3'b000} +: DATA_W] <= push_byte;
          acc_cnt <= acc_cnt + 1'b1;
        end
      end else if (fin_en && (acc_cnt != '0)) begin
        packed_bytes  <= acc;
        byte_count    <= acc_cnt;
        last_for_item <= 1'b1;
        stream_done   <= fin_term;
        acc           <= '0;
        acc_cnt       <= '0;
      end
    end
  end

  `BRLE_ASSERT(a_out_count, clk, rst, out_valid |-> ((byte_count != '0) && (byte_count <= CNT_W'(WORD_BYTES))), "bad byte count")
  `BRLE_NEVER(a_done_last, clk, rst, out_valid && stream_done && !last_for_item, "terminator word not last")
  `BRLE_ASSERT(a_lit_index, clk, rst, (state == B_LRD) |-> (idx < cur_arg[LC_W-1:0]), "literal read past count")

endmodule
`default_nettype wire

// ===== rtl/core/byte_run_length_encoder.sv =====
// Byte run-length encoder top level: front, command queue, back and the
// literal buffer RAM. Depends on brle_pkg and all brle_* modules.
//
// Input channel: one raw byte per transfer (data_byte), with is_final set on
// the last byte of a stream. Output channel: one word per transfer holding
// one to eight encoded bytes, first byte in bits 7:0, byte_count valid bytes,
// last_for_item on the final word caused by an input byte and stream_done
// on the word that carries the zero terminator. A byte that causes no
// encoded bytes produces no transfer.
// For each input byte the front captures it, evaluates the run and ends the
// item. A closing run adds a flush check plus its header or the bytes it adds
// to the literal, and the end of a stream adds a final flush and the terminator.
// The front holds literal writes until an earlier literal flush has been read
// out. The back emits one byte per cycle for headers and run values while the
// output is not stalled, and reads each literal RAM byte in a read state
// then a write state. Reset clears the run, literal count, queue and output
// register; the literal RAM is not cleared. When the receiver stalls the
// output word holds, the back stops, and once the four-entry queue fills
// the front stalls the input channel.
`default_nettype none
module byte_run_length_encoder import brle_pkg::*; #(
  parameter int LIT_MAX = LIT_MAX_DEFAULT,
  parameter int RUN_MAX = RUN_MAX_DEFAULT
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [DATA_W-1:0] data_byte,
  input  wire logic              is_final,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic      [WORD_W-1:0] packed_bytes,
  output logic      [CNT_W-1:0]  byte_count,
  output logic                   last_for_item,
  output logic                   stream_done
);

  localparam int AW = $clog2(LIT_MAX);

  logic              q_push;
  cmd_t              q_wr_cmd;
  logic              q_full;
  logic              q_pop;
  cmd_t              q_rd_cmd;
  logic              q_empty;
  logic              flush_done;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  brle_front #(
    .LIT_MAX(LIT_MAX),
    .RUN_MAX(RUN_MAX)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .data_byte (data_byte),
    .is_final  (is_final),
    .q_push    (q_push),
    .q_cmd     (q_wr_cmd),
    .q_full    (q_full),
    .flush_done(flush_done),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata)
  );

  brle_cmd_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wr_cmd(q_wr_cmd),
    .full  (q_full),
    .pop   (q_pop),
    .rd_cmd(q_rd_cmd),
    .empty (q_empty)
  );

  brle_ram #(
    .WIDTH(DATA_W),
    .DEPTH(LIT_MAX)
  ) u_lit_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  brle_back #(
    .LIT_MAX(LIT_MAX)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_cmd        (q_rd_cmd),
    .q_pop        (q_pop),
    .flush_done   (flush_done),
    .ram_re       (ram_re),
    .ram_raddr    (ram_raddr),
    .ram_rdata    (ram_rdata),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .packed_bytes (packed_bytes),
    .byte_count   (byte_count),
    .last_for_item(last_for_item),
    .stream_done  (stream_done)
  );

endmodule
`default_nettype wire

// ===== bench/tb_byte_run_length_encoder.sv =====
// Self-checking bench for byte_run_length_encoder: random and directed byte
// streams in, packed encoded words out, checked against a run-length predictor.
// Depends on brle_pkg and the encoder RTL.
`default_nettype none
module tb_byte_run_length_encoder;
  import brle_pkg::*;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              fin;
  } raw_byte_t;

  typedef struct packed {
    logic [WORD_W-1:0] word_bytes;
    logic [CNT_W-1:0]  cnt;
    logic              last;
    logic              done;
  } enc_word_t;

  logic              clk;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [DATA_W-1:0] data_byte = '0;
  logic              is_final = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [WORD_W-1:0] packed_bytes;
  logic [CNT_W-1:0]  byte_count;
  logic              last_for_item;
  logic              stream_done;

  raw_byte_t   pending_bytes[$];
  enc_word_t   expected_words[$];
  logic [7:0]  out_bytes[$];
  logic [7:0]  lit_buf[LIT_MAX_DEFAULT];
  int unsigned lit_len = 0;
  logic [7:0]  run_byte = '0;
  int unsigned run_len = 0;

  int          err_count = 0;
  int          bytes_in = 0;
  int          cyc = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;
  logic        in_took = 1'b0;
  logic        quiet;
  enc_word_t   exp_w;

  assign quiet = (cyc >= 20 && cyc < 220);

  byte_run_length_encoder DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .data_byte(data_byte), .is_final(is_final),
    .out_valid(out_valid), .out_stall(out_stall),
    .packed_bytes(packed_bytes), .byte_count(byte_count),
    .last_for_item(last_for_item), .stream_done(stream_done)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic note_mismatch(string msg);
    $display("%0t: %s", $time, msg);
    err_count++;
  endtask

  function void emit_literal();
    if (lit_len != 0) begin
      out_bytes.push_back(8'(lit_len));
      for (int i = 0; i < lit_len; i++) out_bytes.push_back(lit_buf[i]);
      lit_len = 0;
    end
  endfunction

  function void close_run(int unsigned len, logic [7:0] val, bit forced);
    if (forced || len >= RUN_MIN || lit_len + len > LIT_MAX_DEFAULT) emit_literal();
    if (len >= RUN_MIN) begin
      out_bytes.push_back(HDR_BASE - 8'(len - RUN_MIN));
      out_bytes.push_back(val);
    end else begin
      for (int i = 0; i < len; i++) begin
        if (lit_len < LIT_MAX_DEFAULT) begin
          lit_buf[lit_len] = val;
          lit_len++;
        end
      end
    end
  endfunction

  function void predict_encoding(logic [7:0] b, logic fin);
    int unsigned n;
    int unsigned cnt;
    enc_word_t   w;
    out_bytes.delete();
    if (run_len != 0 && b == run_byte && run_len < RUN_MAX_DEFAULT) begin
      run_len++;
      if (run_len >= RUN_MAX_DEFAULT) begin
        close_run(run_len, run_byte, 1'b0);
        run_len = 0;
      end
    end else begin
      if (run_len != 0) close_run(run_len, run_byte, 1'b0);
      run_byte = b;
      run_len = 1;
    end
    if (fin) begin
      if (run_len != 0) close_run(run_len, run_byte, 1'b1);
      run_len = 0;
      run_byte = '0;
      emit_literal();
      out_bytes.push_back(TERM_BYTE);
    end
    n = out_bytes.size();
    for (int k = 0; k * 8 < n; k++) begin
      cnt = n - k * 8;
      if (cnt > 8) cnt = 8;
      w.word_bytes = '0;
      for (int j = 0; j < cnt; j++) w.word_bytes[8*j +: 8] = out_bytes[k*8 + j];
      w.cnt = CNT_W'(cnt);
      w.last = ((k + 1) * 8 >= n);
      w.done = fin && w.last;
      expected_words.push_back(w);
    end
  endfunction

  task automatic push_run(logic [7:0] v, int len, bit fin_last);
    raw_byte_t rb;
    for (int i = 0; i < len; i++) begin
      rb.value = v;
      rb.fin = fin_last && (i == len - 1);
      pending_bytes.push_back(rb);
    end
  endtask

  task automatic push_random_stream();
    int         segs;
    int         len;
    int         r;
    logic [7:0] v;
    logic [7:0] prev;
    segs = $urandom_range(12, 1);
    prev = '0;
    for (int s = 0; s < segs; s++) begin
      r = $urandom_range(99);
      if (r < 55) len = 1;
      else if (r < 75) len = 2;
      else if (r < 95) len = $urandom_range(10, 3);
      else len = $urandom_range(133, 128);
      v = 8'($urandom_range(255));
      if (s != 0 && v == prev && $urandom_range(9) != 0) v = ~prev;
      push_run(v, len, s == segs - 1);
      prev = v;
    end
  endtask

  always @(posedge clk) begin
    if (!rst) cyc <= cyc + 1;
    in_took <= !rst && in_valid && !in_stall;
    if (!rst && in_valid && !in_stall) begin
      predict_encoding(data_byte, is_final);
      bytes_in <= bytes_in + 1;
    end
    if (!rst && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        note_mismatch($sformatf("unexpected word %h count %0d", packed_bytes, byte_count));
      end else begin
        exp_w = expected_words.pop_front();
        if (packed_bytes !== exp_w.word_bytes)
          note_mismatch($sformatf("packed_bytes %h, expected %h", packed_bytes,
                                  exp_w.word_bytes));
        if (byte_count !== exp_w.cnt)
          note_mismatch($sformatf("byte_count %0d, expected %0d", byte_count, exp_w.cnt));
        if (last_for_item !== exp_w.last)
          note_mismatch($sformatf("last_for_item %b, expected %b", last_for_item,
                                  exp_w.last));
        if (stream_done !== exp_w.done)
          note_mismatch($sformatf("stream_done %b, expected %b", stream_done, exp_w.done));
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (pending_bytes.size() != 0 && (quiet || $urandom_range(99) >= 20)) begin
        data_byte <= pending_bytes[0].value;
        is_final <= pending_bytes[0].fin;
        void'(pending_bytes.pop_front());
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // The receiver holds off once for a long stretch so the encoder backs up
  // and stalls its input while transfers keep being offered.
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (bytes_in >= 60 && !hold_done) begin
      out_stall <= 1'b1;
      hold_left <= 300;
      hold_done <= 1'b1;
    end else begin
      out_stall <= !quiet && ($urandom_range(99) < 20);
    end
  end

  initial begin
    logic [7:0] v;
    logic [7:0] prev;
    push_run(8'h00, 1, 1'b1);
    push_run(8'hFF, 3, 1'b1);
    push_run(8'hAA, 1, 1'b0);
    push_run(8'h55, 2, 1'b0);
    push_run(8'h01, 4, 1'b0);
    push_run(8'h80, 1, 1'b1);
    push_run(8'h12, 2, 1'b1);
    push_run(8'h01, 1, 1'b0);
    push_run(8'h02, 1, 1'b0);
    push_run(8'h33, 5, 1'b1);
    while (pending_bytes.size() < 60) push_random_stream();
    // Enough distinct single bytes to overflow the literal buffer.
    prev = '0;
    for (int i = 0; i < 130; i++) begin
      do v = 8'($urandom_range(255)); while (v == prev);
      push_run(v, 1, i == 129);
      prev = v;
    end

    repeat (9) @(negedge clk);
    rst <= 1'b0;
    while (pending_bytes.size() != 0 || in_valid) @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (err_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
`default_nettype wire
